// File: design/trial_division_prime_test_top_defines.svh
// Assertion macros shared by the checker file of the primality test block.
// Needs nothing else; include by bare file name.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TDPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tdpt_pkg.sv
// Shared types and constants of the trial division primality test block.
// No dependencies.
package tdpt_pkg;

    localparam int FIRST_DIVISOR   = 3;
    localparam int ONLY_EVEN_PRIME = 2;
    localparam int OUT_TDATA_W     = 8;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

// File: design/tdpt_rem_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg.
module tdpt_rem_unit #(
    parameter int VALUE_BITS = 31,
    parameter int DIV_W      = 17
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [VALUE_BITS-1:0]       i_dividend,
    input  logic [DIV_W-1:0]            i_divisor,
    output tdpt_pkg::t_rem_status       o_status
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  r_busy,     n_busy;
    logic [CNT_W-1:0]      r_count,    n_count;
    logic [VALUE_BITS-1:0] r_dividend, n_dividend;
    logic [DIV_W-1:0]      r_rem,      n_rem;
    tdpt_pkg::t_rem_status r_status,   n_status;

    logic [DIV_W:0]        w_part;
    logic [DIV_W+1:0]      w_diff;
    logic [DIV_W-1:0]      w_rem_step;

    always_comb begin
        w_part     = {r_rem, r_dividend[VALUE_BITS-1]};
        w_diff     = {1'b0, w_part} - {2'b00, i_divisor};
        w_rem_step = w_diff[DIV_W+1] ? w_part[DIV_W-1:0] : w_diff[DIV_W-1:0];

        n_busy      = r_busy;
        n_count     = r_count;
        n_dividend  = r_dividend;
        n_rem       = r_rem;
        n_status    = r_status;
        n_status.done = 1'b0;

        if (i_start) begin
            n_busy     = 1'b1;
            n_count    = CNT_W'(VALUE_BITS);
            n_dividend = i_dividend;
            n_rem      = '0;
        end else if (r_busy) begin
            n_dividend = {r_dividend[VALUE_BITS-2:0], 1'b0};
            n_rem      = w_rem_step;
            n_count    = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_busy        = 1'b0;
                n_status.done = 1'b1;
                n_status.zero = (w_rem_step == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_status <= '0;
        end else begin
            r_busy   <= n_busy;
            r_status <= n_status;
        end
        r_count    <= n_count;
        r_dividend <= n_dividend;
        r_rem      <= n_rem;
    end

    assign o_status = r_status;

endmodule

// File: design/trial_division_prime_test_top.sv
// Trial division primality test: top level with sequencer and output register.
// Depends on tdpt_pkg and tdpt_rem_unit.
//
// Takes one candidate per input beat and returns one beat with is_prime.
// Even candidates skip the division (prime only for 2). Odd candidates are
// divided by 3, 5, 7, ... while divisor squared <= candidate, each trial
// costing one pass through the single bit-serial remainder unit; a 31-bit
// prime near 2^31 needs about 23170 trials. The divisor square is kept by
// adding 4*d + 4 per step. Candidate 1 reports prime. s_axis_tready is high
// only in the idle state: it drops while a test runs and while a finished
// result waits for the output register to drain; a result in the output
// register does not block the next candidate.
module trial_division_prime_test_top #(
    parameter  int VALUE_BITS = 31,
    localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [IN_TDATA_W-1:0]            s_axis_tdata,  // [VALUE_BITS-1:0] candidate
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tdpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [0] is_prime
);

    localparam int DIV_W = VALUE_BITS / 2 + 2;
    localparam int SQ_W  = VALUE_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state,     n_state;
    logic [VALUE_BITS-1:0] r_value,     n_value;
    logic [DIV_W-1:0]      r_div,       n_div;
    logic [SQ_W-1:0]       r_sq,        n_sq;
    logic                  r_result,    n_result;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_prime, n_out_prime;

    logic                  w_start;
    logic [VALUE_BITS-1:0] w_cand;
    tdpt_pkg::t_rem_status w_rem;

    assign w_cand = s_axis_tdata[VALUE_BITS-1:0];

    tdpt_rem_unit #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_W      (DIV_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_value),
        .i_divisor  (r_div),
        .o_status   (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_div       = r_div;
        n_sq        = r_sq;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_prime = r_out_prime;
        w_start     = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_value = w_cand;
                    n_div   = DIV_W'(tdpt_pkg::FIRST_DIVISOR);
                    n_sq    = SQ_W'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
                    if (!w_cand[0]) begin
                        n_result = (w_cand == VALUE_BITS'(tdpt_pkg::ONLY_EVEN_PRIME));
                        n_state  = S_DONE;
                    end else begin
                        n_state  = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sq > {1'b0, r_value}) begin
                    n_result = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    w_start  = 1'b1;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rem.done) begin
                    if (w_rem.zero) begin
                        n_result = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        n_sq    = r_sq + SQ_W'({r_div, 2'b00}) + SQ_W'(4);
                        n_div   = r_div + DIV_W'(2);
                        n_state = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_value     <= n_value;
        r_div       <= n_div;
        r_sq        <= n_sq;
        r_result    <= n_result;
        r_out_prime <= n_out_prime;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(tdpt_pkg::OUT_TDATA_W - 1){1'b0}}, r_out_prime};

endmodule

// File: design/tdpt_checker.sv
// Port-level checks of the primality test top level, bound to it below.
// Depends on tdpt_pkg and trial_division_prime_test_top_defines.svh.
`include "trial_division_prime_test_top_defines.svh"

module tdpt_checker #(
    parameter  int VALUE_BITS = 31,
    localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [IN_TDATA_W-1:0]            s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tdpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic w_in_beat;
    assign w_in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);

    `TDPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped or changed while stalled")
    `TDPT_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, !s_axis_tready, "input taken while a test is running")
    `TDPT_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[tdpt_pkg::OUT_TDATA_W-1:1] == '0, "output padding bits not zero")
    `TDPT_ASSERT_NOW(a_result_on_idle, i_clk, i_rst_n, $rose(s_axis_tready), m_axis_tvalid, "test finished without a result beat")

endmodule

bind trial_division_prime_test_top tdpt_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_tdpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
